### rtl/assert_macros.svh
// Assertion macros shared by the matrix product engine modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/mm_pkg.sv
// Types, codes and defaults shared by the matrix product engine.
package mm_pkg;

	localparam int MAX_DIM_DEF   = 16;
	localparam int FRAC_BITS_DEF = 16;
	localparam int MAX_OUT_COLS  = 16;
	localparam int DIM_W         = 5;
	localparam int IDX_W         = 4;
	localparam int VAL_W         = 32;
	localparam int CFG_IDX_W     = 3;

	localparam logic [1:0] KIND_LOAD_A = 2'd0;
	localparam logic [1:0] KIND_LOAD_B = 2'd1;
	localparam logic [1:0] KIND_ROW    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_A_ROWS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_A_COLS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B_ROWS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B_COLS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_ROWS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_COLS = 3'd5;

	typedef enum logic [1:0] {
		ST_OK,
		ST_OPERAND,
		ST_DEST,
		ST_ROW
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLEAR,
		S_ISSUE,
		S_WAIT,
		S_EMIT
	} ctl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             wr_a;
		logic             wr_b;
		logic             rd;
		logic             acc_clear;
		logic             emit;
		status_t          status;
		logic             last;
		logic [IDX_W-1:0] out_row;
		logic [IDX_W-1:0] out_col;
	} dp_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic busy;
		logic out_free;
	} dp_status_t;

endpackage

### rtl/mm_datapath.sv
// Datapath: element stores, multiply-accumulate pipeline, saturation and output register.
`include "assert_macros.svh"

module mm_datapath import mm_pkg::*; #(
	parameter int MAX_DIM   = MAX_DIM_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int AW        = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	input  logic [AW-1:0]    wr_addr,
	input  logic [AW-1:0]    a_raddr,
	input  logic [AW-1:0]    b_raddr,
	input  logic [VAL_W-1:0] entry_value,
	output dp_status_t       dp_st,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [39:0]      m_tdata,  // product_value[31:0], out_row[35:32], out_col[39:36]
	output logic [1:0]       m_tuser,  // status[1:0]
	output logic             m_tlast
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int ACC_W = 2 * VAL_W + $clog2(MAX_DIM) + 1;

	logic [VAL_W-1:0] a_mem [DEPTH];
	logic [VAL_W-1:0] b_mem [DEPTH];

	logic [VAL_W-1:0]          a_rd_q, b_rd_q;
	logic                      v1_q, v2_q;
	logic signed [2*VAL_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   shifted;
	logic [VAL_W-1:0]          sat_val;
	logic                      fits;

	logic             out_valid_q;
	logic [VAL_W-1:0] out_value_q;
	logic [IDX_W-1:0] out_row_q, out_col_q;
	status_t          out_status_q;
	logic             out_last_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_a) begin
			a_mem[wr_addr] <= entry_value;
		end
		if (cmd.wr_b) begin
			b_mem[wr_addr] <= entry_value;
		end
		if (cmd.rd) begin
			a_rd_q <= a_mem[a_raddr];
			b_rd_q <= b_mem[b_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			v1_q <= cmd.rd;
			v2_q <= v1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (v1_q) begin
			prod_s2 <= $signed(a_rd_q) * $signed(b_rd_q);
		end
		if (cmd.acc_clear) begin
			acc_q <= '0;
		end else if (v2_q) begin
			acc_q <= acc_q + {{(ACC_W-2*VAL_W){prod_s2[2*VAL_W-1]}}, prod_s2};
		end
	end

	// Drop the fraction bits of the exact sum, then clamp to the 32-bit range.
	always_comb begin
		shifted = acc_q >>> FRAC_BITS;
		fits    = (&shifted[ACC_W-1:VAL_W-1]) | ~(|shifted[ACC_W-1:VAL_W-1]);
		if (fits) begin
			sat_val = shifted[VAL_W-1:0];
		end else if (shifted[ACC_W-1]) begin
			sat_val = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			sat_val = {1'b0, {(VAL_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_value_q  <= (cmd.status == ST_OK) ? sat_val : '0;
			out_row_q    <= cmd.out_row;
			out_col_q    <= cmd.out_col;
			out_status_q <= cmd.status;
			out_last_q   <= cmd.last;
		end
	end

	assign dp_st.busy     = v1_q | v2_q;
	assign dp_st.out_free = ~out_valid_q | m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_col_q, out_row_q, out_value_q};
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

	`ASSERT_NEXT(a_pipe_adv, clk, arst_n, v1_q, v2_q, "read stage did not advance to product stage")
	`ASSERT_NEXT(a_emit_valid, clk, arst_n, cmd.emit, m_tvalid, "emitted result not presented")
	`ASSERT_IMPLIES(a_err_shape, clk, arst_n, m_tvalid && (m_tuser != ST_OK), m_tlast && (m_tdata[31:0] == 32'd0), "error result not single and zero")

endmodule

### rtl/mm_ctrl.sv
// Controller: configuration registers, dimension checks and the row/column/inner sequencer.
`include "assert_macros.svh"

module mm_ctrl import mm_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF,
	parameter int AW      = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [1:0]           kind,
	input  logic [IDX_W-1:0]     row_index,
	input  logic [IDX_W-1:0]     col_index,
	input  dp_status_t           dp_st,
	output dp_cmd_t              cmd,
	output logic [AW-1:0]        wr_addr,
	output logic [AW-1:0]        a_raddr,
	output logic [AW-1:0]        b_raddr
);

	localparam int KW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int IW = $clog2(MAX_DIM + 1);

	ctl_state_t state_q, state_d;

	logic [DIM_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q, dest_rows_q, dest_cols_q;

	logic [IDX_W-1:0] row_q, row_d;
	logic [IDX_W-1:0] j_q, j_d;
	logic [KW-1:0]    k_q, k_d;
	logic [IW-1:0]    inner_q, inner_d;
	logic [DIM_W-1:0] ncols_q, ncols_d;
	status_t          status_q, status_d;

	logic    accept;
	logic    last_k, last_j;
	status_t chk;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q    <= DIM_W'(1);
			a_cols_q    <= DIM_W'(1);
			b_rows_q    <= DIM_W'(1);
			b_cols_q    <= DIM_W'(1);
			dest_rows_q <= DIM_W'(1);
			dest_cols_q <= DIM_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_A_ROWS:    a_rows_q    <= cfg_data;
				REG_A_COLS:    a_cols_q    <= cfg_data;
				REG_B_ROWS:    b_rows_q    <= cfg_data;
				REG_B_COLS:    b_cols_q    <= cfg_data;
				REG_DEST_ROWS: dest_rows_q <= cfg_data;
				REG_DEST_COLS: dest_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Checks run in priority order: operands, destination, requested row.
	always_comb begin
		if (a_cols_q != b_rows_q) begin
			chk = ST_OPERAND;
		end else if (a_rows_q != dest_rows_q || b_cols_q != dest_cols_q) begin
			chk = ST_DEST;
		end else if (int'(row_index) >= int'(a_rows_q) || int'(row_index) >= MAX_DIM) begin
			chk = ST_ROW;
		end else begin
			chk = ST_OK;
		end
	end

	assign accept = s_tvalid & s_tready;
	assign last_k = (IW'(k_q) + IW'(1)) == inner_q;
	assign last_j = (DIM_W'(j_q) + DIM_W'(1)) == ncols_q;

	assign wr_addr = AW'(row_index) * AW'(MAX_DIM) + AW'(col_index);
	assign a_raddr = AW'(row_q) * AW'(MAX_DIM) + AW'(k_q);
	assign b_raddr = AW'(k_q) * AW'(MAX_DIM) + AW'(j_q);

	always_comb begin
		state_d     = state_q;
		row_d       = row_q;
		j_d         = j_q;
		k_d         = k_q;
		inner_d     = inner_q;
		ncols_d     = ncols_q;
		status_d    = status_q;
		s_tready    = 1'b0;
		cmd         = '0;
		cmd.status  = status_q;
		cmd.out_row = row_q;
		cmd.out_col = j_q;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				row_d    = row_index;
				j_d      = '0;
				k_d      = '0;
				inner_d  = (int'(a_cols_q) > MAX_DIM) ? IW'(MAX_DIM) : IW'(a_cols_q);
				if (int'(b_cols_q) > MAX_DIM || int'(b_cols_q) > MAX_OUT_COLS) begin
					ncols_d = (MAX_DIM < MAX_OUT_COLS) ? DIM_W'(MAX_DIM) : DIM_W'(MAX_OUT_COLS);
				end else begin
					ncols_d = b_cols_q;
				end
				status_d = chk;
				if (accept) begin
					case (kind)
						KIND_LOAD_A, KIND_LOAD_B: begin
							// Drop elements outside the stores.
							if (int'(row_index) < MAX_DIM && int'(col_index) < MAX_DIM) begin
								cmd.wr_a = (kind == KIND_LOAD_A);
								cmd.wr_b = (kind == KIND_LOAD_B);
							end
						end
						KIND_ROW: begin
							if (chk != ST_OK) begin
								state_d = S_EMIT;
							end else if (ncols_d != '0) begin
								state_d = S_CLEAR;
							end
						end
						default: ;
					endcase
				end
			end
			S_CLEAR: begin
				cmd.acc_clear = 1'b1;
				state_d = (inner_q == '0) ? S_WAIT : S_ISSUE;
			end
			S_ISSUE: begin
				cmd.rd = 1'b1;
				if (last_k) begin
					k_d     = '0;
					state_d = S_WAIT;
				end else begin
					k_d = k_q + KW'(1);
				end
			end
			S_WAIT: begin
				if (!dp_st.busy) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (dp_st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.acc_clear = 1'b1;
					cmd.last      = (status_q != ST_OK) || last_j;
					if (status_q != ST_OK || last_j) begin
						state_d = S_IDLE;
					end else begin
						j_d     = j_q + IDX_W'(1);
						state_d = (inner_q == '0) ? S_WAIT : S_ISSUE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		row_q    <= row_d;
		j_q      <= j_d;
		k_q      <= k_d;
		inner_q  <= inner_d;
		ncols_q  <= ncols_d;
		status_q <= status_d;
	end

	`ASSERT_IMPLIES(a_emit_free, clk, arst_n, cmd.emit, dp_st.out_free, "result emitted into a full output register")
	`ASSERT_IMPLIES(a_accept_quiet, clk, arst_n, accept, !dp_st.busy, "transaction accepted while the pipeline still works")
	`ASSERT_NEXT(a_wait_done, clk, arst_n, (state_q == S_WAIT) && !dp_st.busy, state_q == S_EMIT, "drained pipeline did not lead to emit")

endmodule

### rtl/matrix_multiply.sv
// Top level of the matrix product engine: controller plus datapath.
//
// Channels: s_* takes items (tuser = kind: load A, load B, row request);
// m_* gives result elements of a row request, tlast on the final one;
// cfg_* writes the six dimension registers, always ready, one per cycle.
// A load item gives no result. A row request whose dimension checks
// fail gives one error result, passing through the S_EMIT state into
// the output register. A passing row request gives ncols results; for
// each column the engine issues inner reads through the single
// multiply-accumulate unit, waits for the read and product stages to
// drain, then emits. The single multiplier and the one read port per
// element store set the pace of each column. The next item is accepted
// once the last result of a row sits in the output register, even
// while it is still waiting.
// Reset clears the state machine, the output valid flag and sets all
// dimension registers to 1; the element stores are not cleared, and
// each entry must be loaded before a row request reads it.
// While m_tready stays low the result holds in the output register and
// the engine waits before emitting the next column.
module matrix_multiply import mm_pkg::*; #(
	parameter int MAX_DIM   = MAX_DIM_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [39:0]          s_tdata,  // row_index[3:0], col_index[7:4], entry_value[39:8]
	input  logic [1:0]           s_tuser,  // kind[1:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [39:0]          m_tdata,  // product_value[31:0], out_row[35:32], out_col[39:36]
	output logic [1:0]           m_tuser,  // status[1:0]
	output logic                 m_tlast
);

	localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

	dp_cmd_t       cmd;
	dp_status_t    dp_st;
	logic [AW-1:0] wr_addr, a_raddr, b_raddr;

	mm_ctrl #(
		.MAX_DIM (MAX_DIM),
		.AW      (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.kind      (s_tuser),
		.row_index (s_tdata[3:0]),
		.col_index (s_tdata[7:4]),
		.dp_st     (dp_st),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.a_raddr   (a_raddr),
		.b_raddr   (b_raddr)
	);

	mm_datapath #(
		.MAX_DIM   (MAX_DIM),
		.FRAC_BITS (FRAC_BITS),
		.AW        (AW)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.wr_addr     (wr_addr),
		.a_raddr     (a_raddr),
		.b_raddr     (b_raddr),
		.entry_value (s_tdata[39:8]),
		.dp_st       (dp_st),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

endmodule
